/* rtl/segint_pkg.sv */
// shared widths and stage payload types for the segment intersection test
package segint_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;

    // orientation tests: 0 = c against ab, 1 = d against ab,
    // 2 = a against cd, 3 = b against cd
    localparam int NUM_TESTS = 4;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [CROSS_BITS-1:0] cross_t;

    typedef struct packed {
        diff_t [NUM_TESTS-1:0] u1;
        diff_t [NUM_TESTS-1:0] v1;
        diff_t [NUM_TESTS-1:0] u2;
        diff_t [NUM_TESTS-1:0] v2;
        logic  [NUM_TESTS-1:0] between;
    } prep_t;

    typedef struct packed {
        prod_t [NUM_TESTS-1:0] p1;
        prod_t [NUM_TESTS-1:0] p2;
        logic  [NUM_TESTS-1:0] between;
    } prod_set_t;

    typedef struct packed {
        logic [NUM_TESTS-1:0] pos;
        logic [NUM_TESTS-1:0] zero;
        logic [NUM_TESTS-1:0] between;
    } orient_t;

    // per-stage handshake between the top level and a stage
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

/* rtl/segint_prep.sv */
// first stage: coordinate differences and endpoint between tests
module segint_prep (
    input  logic                   clk,
    input  logic                   rst_n,
    input  segint_pkg::stage_ctl_t ctl,
    input  segint_pkg::coord_t     a_x,
    input  segint_pkg::coord_t     a_y,
    input  segint_pkg::coord_t     b_x,
    input  segint_pkg::coord_t     b_y,
    input  segint_pkg::coord_t     c_x,
    input  segint_pkg::coord_t     c_y,
    input  segint_pkg::coord_t     d_x,
    input  segint_pkg::coord_t     d_y,
    output logic                   valid_reg,
    output segint_pkg::prep_t      data_reg
);

    segint_pkg::prep_t data_next;

    function automatic segint_pkg::diff_t sub(input segint_pkg::coord_t p,
                                              input segint_pkg::coord_t q);
        sub = segint_pkg::diff_t'(p) - segint_pkg::diff_t'(q);
    endfunction

    // r lies within the span of pq on x, or on y when pq is vertical
    function automatic logic span(input segint_pkg::coord_t px,
                                  input segint_pkg::coord_t py,
                                  input segint_pkg::coord_t qx,
                                  input segint_pkg::coord_t qy,
                                  input segint_pkg::coord_t rx,
                                  input segint_pkg::coord_t ry);
        if (px != qx)
        begin
            span = (px <= rx && rx <= qx) || (px >= rx && rx >= qx);
        end
        else
        begin
            span = (py <= ry && ry <= qy) || (py >= ry && ry >= qy);
        end
    endfunction

    always_comb
    begin
        data_next.u1[0] = sub(b_x, a_x);
        data_next.v1[0] = sub(c_y, a_y);
        data_next.u2[0] = sub(c_x, a_x);
        data_next.v2[0] = sub(b_y, a_y);

        data_next.u1[1] = sub(b_x, a_x);
        data_next.v1[1] = sub(d_y, a_y);
        data_next.u2[1] = sub(d_x, a_x);
        data_next.v2[1] = sub(b_y, a_y);

        data_next.u1[2] = sub(d_x, c_x);
        data_next.v1[2] = sub(a_y, c_y);
        data_next.u2[2] = sub(a_x, c_x);
        data_next.v2[2] = sub(d_y, c_y);

        data_next.u1[3] = sub(d_x, c_x);
        data_next.v1[3] = sub(b_y, c_y);
        data_next.u2[3] = sub(b_x, c_x);
        data_next.v2[3] = sub(d_y, c_y);

        data_next.between[0] = span(a_x, a_y, b_x, b_y, c_x, c_y);
        data_next.between[1] = span(a_x, a_y, b_x, b_y, d_x, d_y);
        data_next.between[2] = span(c_x, c_y, d_x, d_y, a_x, a_y);
        data_next.between[3] = span(c_x, c_y, d_x, d_y, b_x, b_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/segint_mul.sv */
// second stage: the eight cross-product terms
module segint_mul (
    input  logic                   clk,
    input  logic                   rst_n,
    input  segint_pkg::stage_ctl_t ctl,
    input  segint_pkg::prep_t      data,
    output logic                   valid_reg,
    output segint_pkg::prod_set_t  data_reg
);

    segint_pkg::prod_set_t data_next;

    always_comb
    begin
        for (int i = 0; i < segint_pkg::NUM_TESTS; i++)
        begin
            data_next.p1[i] = $signed(data.u1[i]) * $signed(data.v1[i]);
            data_next.p2[i] = $signed(data.u2[i]) * $signed(data.v2[i]);
        end
        data_next.between = data.between;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/segint_orient.sv */
// third stage: exact cross products reduced to orientation signs
module segint_orient (
    input  logic                   clk,
    input  logic                   rst_n,
    input  segint_pkg::stage_ctl_t ctl,
    input  segint_pkg::prod_set_t  data,
    output logic                   valid_reg,
    output segint_pkg::orient_t    data_reg
);

    segint_pkg::orient_t data_next;
    segint_pkg::cross_t  cross_val [segint_pkg::NUM_TESTS];

    always_comb
    begin
        for (int i = 0; i < segint_pkg::NUM_TESTS; i++)
        begin
            cross_val[i] = segint_pkg::cross_t'($signed(data.p1[i]))
                         - segint_pkg::cross_t'($signed(data.p2[i]));
            data_next.zero[i] = (cross_val[i] == '0);
            data_next.pos[i]  = !cross_val[i][segint_pkg::CROSS_BITS-1]
                             && (cross_val[i] != '0);
        end
        data_next.between = data.between;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

/* rtl/segint_decide.sv */
// last stage: proper crossing or touch decision and the output register
module segint_decide (
    input  logic                   clk,
    input  logic                   rst_n,
    input  segint_pkg::stage_ctl_t ctl,
    input  segint_pkg::orient_t    data,
    output logic                   valid_reg,
    output logic                   crosses_reg,
    output logic                   touching_reg
);

    logic proper;
    logic touch;
    logic crosses_next;
    logic touching_next;

    always_comb
    begin
        proper = (data.zero == '0)
              && (data.pos[0] != data.pos[1])
              && (data.pos[2] != data.pos[3]);
        // an endpoint is on the other segment when collinear and within its span
        touch         = |(data.zero & data.between);
        crosses_next  = proper || touch;
        touching_next = !proper && touch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.advance)
        begin
            valid_reg <= ctl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance && ctl.valid)
        begin
            crosses_reg  <= crosses_next;
            touching_reg <= touching_next;
        end
    end

endmodule

/* rtl/segment_intersection_test.sv */
// top level of the segment intersection test pipeline
//
// Takes one segment pair per cycle while the output side keeps taking results
// and returns one result per pair, in order. The four register stages are:
// coordinate differences with the endpoint span compares, eight signed 25 by
// 25 multipliers, the cross-product subtracts that give the four orientations,
// and the decision that feeds the output register. Every stage holds its
// request while the one after it is full and not moving, so in_ready drops
// only when all four stages are occupied and the output is not being taken.
// There is no state between pairs and no warm-up after reset.
module segment_intersection_test (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  segint_pkg::coord_t a_x,
    input  segint_pkg::coord_t a_y,
    input  segint_pkg::coord_t b_x,
    input  segint_pkg::coord_t b_y,
    input  segint_pkg::coord_t c_x,
    input  segint_pkg::coord_t c_y,
    input  segint_pkg::coord_t d_x,
    input  segint_pkg::coord_t d_y,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               crosses,
    output logic               touching
);

    segint_pkg::stage_ctl_t ctl_prep;
    segint_pkg::stage_ctl_t ctl_mul;
    segint_pkg::stage_ctl_t ctl_orient;
    segint_pkg::stage_ctl_t ctl_decide;

    logic                  prep_valid;
    logic                  mul_valid;
    logic                  orient_valid;
    segint_pkg::prep_t     prep_data;
    segint_pkg::prod_set_t mul_data;
    segint_pkg::orient_t   orient_data;

    // a stage moves when it is empty or the next stage moves too
    always_comb
    begin
        ctl_decide.advance = !out_valid || out_ready;
        ctl_orient.advance = !orient_valid || ctl_decide.advance;
        ctl_mul.advance    = !mul_valid || ctl_orient.advance;
        ctl_prep.advance   = !prep_valid || ctl_mul.advance;

        ctl_prep.valid     = in_valid;
        ctl_mul.valid      = prep_valid;
        ctl_orient.valid   = mul_valid;
        ctl_decide.valid   = orient_valid;

        in_ready           = ctl_prep.advance;
    end

    segint_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_prep),
        .a_x       (a_x),
        .a_y       (a_y),
        .b_x       (b_x),
        .b_y       (b_y),
        .c_x       (c_x),
        .c_y       (c_y),
        .d_x       (d_x),
        .d_y       (d_y),
        .valid_reg (prep_valid),
        .data_reg  (prep_data)
    );

    segint_mul u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_mul),
        .data      (prep_data),
        .valid_reg (mul_valid),
        .data_reg  (mul_data)
    );

    segint_orient u_orient (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl_orient),
        .data      (mul_data),
        .valid_reg (orient_valid),
        .data_reg  (orient_data)
    );

    segint_decide u_decide (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl_decide),
        .data         (orient_data),
        .valid_reg    (out_valid),
        .crosses_reg  (crosses),
        .touching_reg (touching)
    );

endmodule

/* rtl/segint_checker.sv */
// port-level assertions for the segment intersection test and their bind
module segint_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input segint_pkg::coord_t a_x,
    input segint_pkg::coord_t a_y,
    input segint_pkg::coord_t b_x,
    input segint_pkg::coord_t b_y,
    input segint_pkg::coord_t c_x,
    input segint_pkg::coord_t c_y,
    input segint_pkg::coord_t d_x,
    input segint_pkg::coord_t d_y,
    input logic               out_valid,
    input logic               out_ready,
    input logic               crosses,
    input logic               touching
);

    logic [8*segint_pkg::COORD_BITS-1:0] in_bus;

    assign in_bus = {a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y};

    // a stalled result holds
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(crosses) && $stable(touching);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result changed or dropped");

    // a touch is always reported as a crossing
    property p_touch_implies_cross;
        @(posedge clk) disable iff (!rst_n)
        out_valid && touching |-> crosses;
    endproperty
    a_touch_implies_cross: assert property (p_touch_implies_cross)
        else $error("touching set without crosses");

    // an open output keeps the whole pipeline moving
    property p_full_rate;
        @(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready;
    endproperty
    a_full_rate: assert property (p_full_rate)
        else $error("input stalled while output is ready");

    // fixed latency when the output side keeps taking results
    property p_latency;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_bus == in_bus)) ##1 out_ready ##1 out_ready ##1 out_ready
            |=> out_valid;
    endproperty
    a_latency: assert property (p_latency)
        else $error("accepted request did not reach the output in four cycles");

endmodule

bind segment_intersection_test segint_checker u_segint_checker (.*);

/* bench/tb_segment_intersection_test.sv */
// self-checking testbench for the segment intersection test pipeline
module tb_segment_intersection_test;

    localparam longint COORD_MAX = 8388607;
    localparam longint COORD_MIN = -8388608;
    localparam int NUM_RANDOM = 530;
    localparam int IDLE_LIMIT = 2000;
    localparam int LONG_HOLD_AT = 120;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic crosses;
        logic touching;
    } verdict_t;

    class verdict_book;
        verdict_t pending_verdicts[$];
        int mismatches = 0;

        // sign of (q - p) x (r - p); 64 bits hold the exact value
        function int orient_sign(longint px, longint py, longint qx, longint qy,
                                 longint rx, longint ry);
            longint cr;
            cr = (qx - px) * (ry - py) - (rx - px) * (qy - py);
            return (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
        endfunction

        function bit lies_on(longint px, longint py, longint qx, longint qy,
                             longint rx, longint ry);
            if (orient_sign(px, py, qx, qy, rx, ry) != 0)
                return 1'b0;
            if (px != qx)
                return (px <= rx && rx <= qx) || (px >= rx && rx >= qx);
            return (py <= ry && ry <= qy) || (py >= ry && ry >= qy);
        endfunction

        function void note_pair(segint_pkg::coord_t ax, segint_pkg::coord_t ay,
                                segint_pkg::coord_t bx, segint_pkg::coord_t by,
                                segint_pkg::coord_t cx, segint_pkg::coord_t cy,
                                segint_pkg::coord_t dx, segint_pkg::coord_t dy);
            int oc, od, oa, ob;
            verdict_t v;
            oc = orient_sign(ax, ay, bx, by, cx, cy);
            od = orient_sign(ax, ay, bx, by, dx, dy);
            oa = orient_sign(cx, cy, dx, dy, ax, ay);
            ob = orient_sign(cx, cy, dx, dy, bx, by);
            v = '0;
            if (oc != 0 && od != 0 && oa != 0 && ob != 0 &&
                ((oc > 0) != (od > 0)) && ((oa > 0) != (ob > 0)))
            begin
                v.crosses = 1'b1;
            end
            else if (lies_on(ax, ay, bx, by, cx, cy) || lies_on(ax, ay, bx, by, dx, dy) ||
                     lies_on(cx, cy, dx, dy, ax, ay) || lies_on(cx, cy, dx, dy, bx, by))
            begin
                v.crosses = 1'b1;
                v.touching = 1'b1;
            end
            pending_verdicts.push_back(v);
        endfunction

        function void check_result(logic got_crosses, logic got_touching);
            verdict_t v;
            if (pending_verdicts.size() == 0)
            begin
                $error("result with no pending request: crosses %0b touching %0b",
                       got_crosses, got_touching);
                mismatches++;
                return;
            end
            v = pending_verdicts.pop_front();
            if (got_crosses !== v.crosses)
            begin
                $error("crosses mismatch: expected %0b, got %0b", v.crosses, got_crosses);
                mismatches++;
            end
            if (got_touching !== v.touching)
            begin
                $error("touching mismatch: expected %0b, got %0b", v.touching, got_touching);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    segint_pkg::coord_t a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y;
    logic               out_valid;
    logic               out_ready;
    logic               crosses;
    logic               touching;

    verdict_book book = new;
    int sent_count = 0;
    int idle_cycles = 0;

    segment_intersection_test dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_x       (a_x),
        .a_y       (a_y),
        .b_x       (b_x),
        .b_y       (b_y),
        .c_x       (c_x),
        .c_y       (c_y),
        .d_x       (d_x),
        .d_y       (d_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .crosses   (crosses),
        .touching  (touching)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            book.note_pair(a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y);
        if (rst_n && out_valid && out_ready)
            book.check_result(crosses, touching);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("segment_intersection_test verification failed");
            $finish;
        end
    end

    // result side: random stalls, quiet stretches, one long hold-off
    initial
    begin
        int taken;
        int stall;
        bit held;
        taken = 0;
        held = 1'b0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (taken == LONG_HOLD_AT && !held)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                held = 1'b1;
            end
            stall = (((taken / 50) % 3) == 1) ? 0 : $urandom_range(0, 3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            taken++;
        end
    end

    task automatic send_pair(input longint ax, input longint ay, input longint bx,
                             input longint by, input longint cx, input longint cy,
                             input longint dx, input longint dy);
        int gap;
        gap = (((sent_count / 40) % 3) == 2) ? 0 : $urandom_range(0, 3);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        a_x <= segint_pkg::coord_t'(ax);
        a_y <= segint_pkg::coord_t'(ay);
        b_x <= segint_pkg::coord_t'(bx);
        b_y <= segint_pkg::coord_t'(by);
        c_x <= segint_pkg::coord_t'(cx);
        c_y <= segint_pkg::coord_t'(cy);
        d_x <= segint_pkg::coord_t'(dx);
        d_y <= segint_pkg::coord_t'(dy);
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent_count++;
    endtask

    function automatic longint any_coord();
        segint_pkg::coord_t t;
        t = segint_pkg::coord_t'($urandom);
        return t;
    endfunction

    function automatic longint spread(int s);
        return longint'($urandom_range(0, 2 * s)) - s;
    endfunction

    function automatic longint clamp(longint v);
        return (v > COORD_MAX) ? COORD_MAX : ((v < COORD_MIN) ? COORD_MIN : v);
    endfunction

    function automatic longint edge_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return 0;
            3: return -1;
            4: return 1;
            5: return COORD_MIN + 1;
            6: return COORD_MAX - 1;
            default: return any_coord();
        endcase
    endfunction

    task automatic send_random_pair();
        longint px[4], py[4];
        longint ux, uy, sx, sy;
        int n, k, sel;
        sel = $urandom_range(0, 9);
        sx = spread(2097152);
        sy = spread(2097152);
        ux = spread(2000);
        uy = spread(2000);
        if ($urandom_range(0, 3) == 0)
        begin
            if ($urandom_range(0, 1) != 0)
                ux = 0;
            else
                uy = 0;
        end
        for (int i = 0; i < 4; i++)
        begin
            px[i] = any_coord();
            py[i] = any_coord();
        end
        case (sel)
            2, 3:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    px[i] = spread(6);
                    py[i] = spread(6);
                end
            end
            4, 5:
            begin
                // one endpoint placed exactly on the other segment
                n = $urandom_range(0, 2000);
                k = $urandom_range(0, n);
                px[0] = sx;
                py[0] = sy;
                px[1] = sx + n * ux;
                py[1] = sy + n * uy;
                px[2] = sx + k * ux;
                py[2] = sy + k * uy;
                if ($urandom_range(0, 1) != 0)
                begin
                    px[3] = px[2] + spread(5000);
                    py[3] = py[2] + spread(5000);
                end
            end
            6:
            begin
                // both segments on one line
                for (int i = 0; i < 4; i++)
                begin
                    k = $urandom_range(0, 2000);
                    px[i] = sx + (k - 1000) * ux;
                    py[i] = sy + (k - 1000) * uy;
                end
            end
            7:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    px[i] = edge_coord();
                    py[i] = edge_coord();
                end
            end
            8:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    px[i] = spread(50);
                    py[i] = spread(50);
                end
                case ($urandom_range(0, 2))
                    0:
                    begin
                        px[1] = px[0];
                        py[1] = py[0];
                    end
                    1:
                    begin
                        px[2] = px[1];
                        py[2] = py[1];
                    end
                    default:
                    begin
                        px[1] = px[0];
                        py[1] = py[0];
                        px[3] = px[2];
                        py[3] = py[2];
                    end
                endcase
            end
            9:
            begin
                // endpoint at or next to the midpoint of the other segment
                px[2] = (px[0] + px[1]) / 2 + spread(1);
                py[2] = (py[0] + py[1]) / 2 + spread(1);
            end
            default: ;
        endcase
        for (int i = 0; i < 4; i++)
        begin
            px[i] = clamp(px[i]);
            py[i] = clamp(py[i]);
        end
        if ($urandom_range(0, 1) != 0)
        begin
            px = '{px[1], px[0], px[2], px[3]};
            py = '{py[1], py[0], py[2], py[3]};
        end
        if ($urandom_range(0, 1) != 0)
        begin
            px = '{px[0], px[1], px[3], px[2]};
            py = '{py[0], py[1], py[3], py[2]};
        end
        if ($urandom_range(0, 1) != 0)
            send_pair(px[2], py[2], px[3], py[3], px[0], py[0], px[1], py[1]);
        else
            send_pair(px[0], py[0], px[1], py[1], px[2], py[2], px[3], py[3]);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        a_x <= '0;
        a_y <= '0;
        b_x <= '0;
        b_y <= '0;
        c_x <= '0;
        c_y <= '0;
        d_x <= '0;
        d_y <= '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_pair(-10, -10, 10, 10, -10, 10, 10, -10);     // proper crossing
        send_pair(0, 0, 10, 0, 0, 1, 10, 1);               // parallel apart
        send_pair(0, 0, 10, 0, 5, 0, 5, 7);                // t junction
        send_pair(0, 0, 5, 5, 5, 5, 9, 0);                 // shared endpoint
        send_pair(0, 0, 10, 0, 5, 0, 15, 0);               // collinear overlap
        send_pair(0, 0, 4, 0, 5, 0, 9, 0);                 // collinear apart
        send_pair(3, 0, 3, 10, 3, 4, 3, 20);               // vertical overlap
        send_pair(3, 0, 3, 4, 3, 5, 3, 9);                 // vertical apart
        send_pair(2, 2, 2, 2, 0, 0, 4, 4);                 // point on segment
        send_pair(2, 3, 2, 3, 0, 0, 4, 4);                 // point off segment
        send_pair(7, 7, 7, 7, 7, 7, 7, 7);                 // two equal points
        send_pair(7, 7, 7, 7, 8, 7, 8, 7);                 // two distinct points
        send_pair(0, 0, 1, 1, 3, 0, 2, 1);                 // lines meet outside
        send_pair(0, 0, 2, 0, 5, 0, 5, 3);                 // collinear end beyond
        send_pair(-1, -1, 0, 0, 0, -1, -1, 0);             // crossing off the grid
        send_pair(0, 0, 0, 5, 1, 0, 1, 5);                 // vertical parallel
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX);
        send_pair(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
                  COORD_MAX - 1, COORD_MAX, COORD_MIN, COORD_MIN + 1);
        send_pair(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                  COORD_MIN + 1, COORD_MAX, COORD_MAX, COORD_MIN + 1);
        send_pair(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_pair(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_pair(24'sh555555, -24'sh2aaaab, -24'sh2aaaab, 24'sh555555,
                  -24'sh555556, -24'sh555556, 24'sh2aaaaa, 24'sh2aaaaa);

        repeat (NUM_RANDOM) send_random_pair();

        @(negedge clk);
        in_valid <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (book.mismatches == 0)
            $display("segment_intersection_test verification clean");
        else
            $display("segment_intersection_test verification failed");
        $finish;
    end

endmodule

/* segment_intersection_test.f */
rtl/segint_pkg.sv
rtl/segint_prep.sv
rtl/segint_mul.sv
rtl/segint_orient.sv
rtl/segint_decide.sv
rtl/segment_intersection_test.sv
rtl/segint_checker.sv
bench/tb_segment_intersection_test.sv
